// ----- design/pcc_pkg.sv -----
`timescale 1ns / 1ps
// constants, register codes and helper functions for pixel_channel_correction
// no dependencies

package pcc_pkg;

  localparam int LEVEL_W           = 16;
  localparam int SET_W             = 16;
  localparam int STR_W             = 15;
  localparam int Q30_W             = 31;
  localparam int FRAC_W            = 24;
  localparam int LOG_STEPS         = 24;
  localparam int EXP_STEPS         = FRAC_W;
  localparam int MAX_CONTRAST_GAIN = 64;
  localparam int CGAIN_W           = $clog2(MAX_CONTRAST_GAIN + 1) + 16;
  localparam logic [CGAIN_W-1:0] CGAIN_MAX = CGAIN_W'(MAX_CONTRAST_GAIN) << 16;
  localparam int DIV_STEPS         = 31;
  localparam int P_W               = 32 + CGAIN_W + 1;
  localparam int V_W               = P_W - 15;
  localparam int W_W               = V_W + 2;
  localparam int NSTAGE            = 5 + LOG_STEPS + 1 + EXP_STEPS + 4;

  typedef enum logic [1:0] {
    REG_CONTRAST   = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_GAMMA      = 2'd2,
    REG_STRENGTH   = 2'd3
  } reg_index_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_GSEL = 7'b0000100,
    ST_GDIV = 7'b0001000,
    ST_GSQ1 = 7'b0010000,
    ST_GSQ2 = 7'b0100000,
    ST_CSEL = 7'b1000000
  } seq_state_t;

  function automatic logic signed [SET_W-1:0] clamp_set(input logic [SET_W-1:0] v);
    logic signed [SET_W-1:0] s;
    s = $signed(v);
    if (s > 16'sd16384) return 16'sd16384;
    else if (s < -16'sd16384) return -16'sd16384;
    else return s;
  endfunction

  // q14 product rounded half away from zero
  function automatic logic signed [SET_W-1:0] mul_q14(input logic signed [SET_W-1:0] a,
                                                       input logic [STR_W-1:0] b);
    logic signed [31:0] p;
    logic [31:0] mag;
    logic [31:0] r;
    p = $signed(a) * $signed({1'b0, b});
    mag = p[31] ? 32'(-p) : 32'(p);
    r = (mag + 32'd8192) >> 14;
    return p[31] ? 16'(-$signed({1'b0, r[15:0]})) : $signed(r[15:0]);
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = x;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // q30 factor 2^-(2^-(idx+1)), elaboration only
  function automatic logic [Q30_W-1:0] pow_factor(input int idx);
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int j = 0; j < EXP_STEPS; j++) begin
      if (j < idx) c = isqrt64(c << 30);
    end
    return c[Q30_W-1:0];
  endfunction

endpackage

// ----- design/pixel_channel_correction.sv -----
`timescale 1ns / 1ps
// gamma, contrast and brightness correction of one 16-bit channel level
// depends on pcc_pkg

// One sample enters per clock while no gain rebuild runs and the two-word
// output buffer has room; the depth is set by 24 squaring stages of the log
// and 24 multiply stages of the power, one 31x31 multiplier each. After reset
// and after every configuration write s_tready is low while the gamma
// exponent and contrast gain are rebuilt, partly by a shared one-bit-per-cycle
// divider. Settings are Q2.14 and are clamped to their legal range.
module pixel_channel_correction
  import pcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [LEVEL_W-1:0] s_tdata,   // level_in
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [LEVEL_W-1:0] m_tdata,   // level_out
  output logic               m_tuser,   // clipped_high
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [SET_W-1:0]   cfg_data
);

  logic [SET_W-1:0] contrast_setting;
  logic [SET_W-1:0] brightness_setting;
  logic [SET_W-1:0] gamma_setting;
  logic [STR_W-1:0] strength;

  logic signed [SET_W-1:0] cs_c, bs_c, gs_c;
  logic [STR_W-1:0]        mult;

  seq_state_t              state;
  logic signed [SET_W-1:0] gm, kq, boff;
  logic [17:0]             g;
  logic [18:0]             e2;
  logic [20:0]             e4;
  logic [CGAIN_W-1:0]      cgain;
  logic                    div_con;
  logic [15:0]             div_rem, div_den;
  logic [Q30_W-1:0]        div_q;
  logic [4:0]              div_cnt;

  logic [16:0]             div_trial;
  logic                    div_ge;
  logic [15:0]             div_rem_next;
  logic [Q30_W-1:0]        div_q_next;
  logic signed [17:0]      gdiff, kdiff;
  logic [15:0]             gden;

  logic adv;
  logic [NSTAGE-1:0] vld;

  assign cs_c = clamp_set(contrast_setting);
  assign bs_c = clamp_set(brightness_setting);
  assign gs_c = clamp_set(gamma_setting);
  assign mult = (strength > 15'd16384) ? 15'd16384 : strength;

  // ---------------------------------------------------------------- settings
  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_setting   <= '0;
      brightness_setting <= '0;
      gamma_setting      <= '0;
      strength           <= 15'd16384;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_CONTRAST:   contrast_setting   <= cfg_data;
        REG_BRIGHTNESS: brightness_setting <= cfg_data;
        REG_GAMMA:      gamma_setting      <= cfg_data;
        REG_STRENGTH:   strength           <= cfg_data[STR_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- derived gains
  assign div_trial    = {div_rem, div_q[Q30_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_ge ? 16'(div_trial - {1'b0, div_den}) : div_trial[15:0];
  assign div_q_next   = {div_q[Q30_W-2:0], div_ge};
  assign gdiff        = 18'sd16384 - 18'(gm);
  assign kdiff        = 18'sd16384 - 18'(kq);
  assign gden         = 16'(18'sd16384 + 18'(gm));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PREP;
    end else if (cfg_we) begin
      state <= ST_PREP;
    end else begin
      unique case (state)
        ST_IDLE: state <= ST_IDLE;
        ST_PREP: state <= ST_GSEL;
        ST_GSEL: state <= gs_c[SET_W-1] ? ST_GSQ1 : ST_GDIV;
        ST_GDIV: begin
          if (div_cnt == 5'(DIV_STEPS - 1)) state <= div_con ? ST_IDLE : ST_GSQ1;
        end
        ST_GSQ1: state <= ST_GSQ2;
        ST_GSQ2: state <= ST_CSEL;
        ST_CSEL: begin
          if (cs_c <= 16'sd0 || kdiff <= 18'sd0) state <= ST_IDLE;
          else state <= ST_GDIV;
        end
        default: state <= ST_PREP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_PREP: begin
        gm   <= mul_q14(gs_c, mult);
        kq   <= mul_q14(cs_c, mult);
        boff <= mul_q14(bs_c, mult);
      end
      ST_GSEL: begin
        g       <= 18'({gdiff[15:0], 2'b00});
        div_con <= 1'b0;
        div_rem <= '0;
        div_den <= gden;
        div_cnt <= '0;
        div_q   <= (31'd1 << 30) + 31'(gden >> 1);
      end
      ST_GDIV: begin
        div_rem <= div_rem_next;
        div_q   <= div_q_next;
        div_cnt <= div_cnt + 5'd1;
        if (div_cnt == 5'(DIV_STEPS - 1)) begin
          if (div_con)
            cgain <= (div_q_next > 31'(CGAIN_MAX)) ? CGAIN_MAX : CGAIN_W'(div_q_next);
          else
            g <= 18'(div_q_next);
        end
      end
      ST_GSQ1: e2 <= 19'((36'(g) * 36'(g) + 36'd32768) >> 16);
      ST_GSQ2: e4 <= 21'((38'(e2) * 38'(e2) + 38'd32768) >> 16);
      ST_CSEL: begin
        div_con <= 1'b1;
        div_rem <= '0;
        div_den <= 16'(kdiff);
        div_cnt <= '0;
        div_q   <= (31'd1 << 30) + 31'(kdiff[15:0] >> 1);
        if (cs_c <= 16'sd0) cgain <= CGAIN_W'({16'(18'sd16384 + 18'(kq)), 2'b00});
        else if (kdiff <= 18'sd0) cgain <= CGAIN_MAX;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output buffer
  logic [LEVEL_W-1:0] ob_level [2];
  logic               ob_clip  [2];
  logic               ob_wp, ob_rp;
  logic [1:0]         ob_cnt;
  logic               push, pop;

  assign adv      = (ob_cnt != 2'd2);
  assign s_tready = adv && (state == ST_IDLE);
  assign m_tvalid = (ob_cnt != 2'd0);
  assign m_tdata  = ob_level[ob_rp];
  assign m_tuser  = ob_clip[ob_rp];
  assign push     = adv && vld[NSTAGE-1];
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], s_tvalid && s_tready};
    end
  end

  // ---------------------------------------------------------------- level to q30
  logic [LEVEL_W-1:0] lvl0;
  logic [Q30_W-1:0]   xa, x2;
  logic [16:0]        r2;
  logic               z1, z2;
  logic [Q30_W-1:0]   r1;
  logic [16:0]        r3;

  assign r1 = (31'(lvl0) << 14) + 31'd32767;
  assign r3 = 17'(r2[15:0]) + 17'(r2[16]);

  always_ff @(posedge clk) begin
    if (adv) begin
      lvl0 <= s_tdata;
      xa   <= (31'(lvl0) << 14) + 31'(r1[30:16]);
      r2   <= 17'(r1[15:0]) + 17'(r1[30:16]);
      z1   <= (lvl0 == '0);
      x2   <= xa + 31'(r2[16]) + 31'(r3 >= 17'd65535);
      z2   <= z1;
    end
  end

  // ---------------------------------------------------------------- normalize
  logic [Q30_W-1:0] na_m, na_m_next, nb_m_next;
  logic [4:0]       na_n, na_n_next, nb_n_next;
  logic             na_z;

  always_comb begin
    na_m_next = x2;
    na_n_next = '0;
    if (na_m_next[30:15] == '0) begin na_m_next = na_m_next << 16; na_n_next += 5'd16; end
    if (na_m_next[30:23] == '0) begin na_m_next = na_m_next << 8;  na_n_next += 5'd8;  end
    if (na_m_next[30:27] == '0) begin na_m_next = na_m_next << 4;  na_n_next += 5'd4;  end
    nb_m_next = na_m;
    nb_n_next = na_n;
    if (nb_m_next[30:29] == '0) begin nb_m_next = nb_m_next << 2;  nb_n_next += 5'd2;  end
    if (nb_m_next[30] == 1'b0)  begin nb_m_next = nb_m_next << 1;  nb_n_next += 5'd1;  end
  end

  // ---------------------------------------------------------------- log2 by squaring
  logic [Q30_W-1:0]  lm [LOG_STEPS+1];
  logic [FRAC_W-1:0] lf [LOG_STEPS+1];
  logic [4:0]        ln [LOG_STEPS+1];
  logic              lz [LOG_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      na_m  <= na_m_next;
      na_n  <= na_n_next;
      na_z  <= z2;
      lm[0] <= nb_m_next;
      ln[0] <= nb_n_next;
      lf[0] <= '0;
      lz[0] <= na_z;
    end
  end

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    logic [61:0] sq;
    assign sq = 62'(lm[i]) * 62'(lm[i]);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sq[61]) begin
          lm[i+1] <= sq[61:31];
          lf[i+1] <= {lf[i][FRAC_W-2:0], 1'b1};
        end else begin
          lm[i+1] <= sq[60:30];
          lf[i+1] <= {lf[i][FRAC_W-2:0], 1'b0};
        end
        ln[i+1] <= ln[i];
        lz[i+1] <= lz[i];
      end
    end
  end

  // ---------------------------------------------------------------- exponent product
  logic [28:0] lneg;
  logic [49:0] tprod;
  logic [33:0] tval;

  assign lneg  = (29'(ln[LOG_STEPS]) << FRAC_W) - 29'(lf[LOG_STEPS]);
  assign tprod = 50'(lneg) * 50'(e4) + 50'd32768;
  assign tval  = tprod[49:16];

  logic [Q30_W-1:0]  er    [EXP_STEPS+1];
  logic [FRAC_W-1:0] ef    [EXP_STEPS+1];
  logic [4:0]        esh   [EXP_STEPS+1];
  logic              ekill [EXP_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      er[0]    <= 31'd1 << 30;
      ef[0]    <= tval[FRAC_W-1:0];
      esh[0]   <= tval[FRAC_W+4:FRAC_W];
      ekill[0] <= lz[LOG_STEPS] || (tval[33:FRAC_W] > 10'd30);
    end
  end

  // ---------------------------------------------------------------- power by factors
  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
    localparam logic [Q30_W-1:0] FAC = pow_factor(i);
    logic [61:0] prod;
    assign prod = 62'(er[i]) * 62'(FAC) + (62'd1 << 29);
    always_ff @(posedge clk) begin
      if (adv) begin
        er[i+1]    <= ef[i][FRAC_W-1-i] ? prod[60:30] : er[i];
        ef[i+1]    <= ef[i];
        esh[i+1]   <= esh[i];
        ekill[i+1] <= ekill[i];
      end
    end
  end

  // ---------------------------------------------------------------- contrast, brightness
  logic [Q30_W-1:0]     u;
  logic signed [P_W-1:0] pp;
  logic signed [V_W-1:0] vv;
  logic [W_W-1:0]        ww;
  logic signed [31:0]    ua;
  logic [P_W-1:0]        pmag;
  logic [P_W-1:0]        psh;
  logic signed [W_W-1:0] wsum;
  logic [46:0]           oprod;
  logic [LEVEL_W-1:0]    res;
  logic                  clip;

  assign ua    = $signed({1'b0, u}) - 32'sd536870912;
  assign pmag  = pp[P_W-1] ? P_W'(-pp) : P_W'(pp);
  assign psh   = (pmag + P_W'(32768)) >> 16;
  assign wsum  = W_W'(vv) + W_W'(32'sd536870912) + (W_W'(boff) <<< 16);
  assign clip  = (ww > W_W'(32'd1073741824));
  assign oprod = (47'(ww[Q30_W-1:0]) << 16) - 47'(ww[Q30_W-1:0]) + (47'd1 << 29);
  assign res   = clip ? '1 : oprod[45:30];

  always_ff @(posedge clk) begin
    if (adv) begin
      u  <= ekill[EXP_STEPS] ? '0 : (er[EXP_STEPS] >> esh[EXP_STEPS]);
      pp <= P_W'(ua) * P_W'($signed({1'b0, cgain}));
      vv <= pp[P_W-1] ? V_W'(-$signed(psh)) : V_W'($signed(psh));
      ww <= wsum[W_W-1] ? '0 : W_W'(wsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wp  <= 1'b0;
      ob_rp  <= 1'b0;
      ob_cnt <= '0;
    end else begin
      if (push) ob_wp <= ~ob_wp;
      if (pop) ob_rp <= ~ob_rp;
      ob_cnt <= ob_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ob_level[ob_wp] <= res;
      ob_clip[ob_wp]  <= clip;
    end
  end

`ifndef SYNTHESIS
  a_ob_bound: assert property (@(posedge clk) disable iff (rst) ob_cnt != 2'd3)
    else $error("output buffer overflow");
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) cfg_we |=> !s_tready)
    else $error("input taken while gains are rebuilt");
  a_clip_full: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser |-> m_tdata == '1)
    else $error("clipped word not at full scale");
  a_gain_cap: assert property (@(posedge clk) disable iff (rst)
      state == ST_IDLE |-> cgain <= CGAIN_MAX)
    else $error("contrast gain above cap");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      vld[NSTAGE-1] && !adv |=> vld[NSTAGE-1])
    else $error("stalled word lost");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for pixel_channel_correction: a gamma, contrast and
// brightness predictor built from 64-bit integer math; depends on pcc_pkg

module tb_top
  import pcc_pkg::*;
();

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [LEVEL_W-1:0] s_tdata = '0;      // level_in
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [LEVEL_W-1:0] m_tdata;           // level_out
  logic               m_tuser;           // clipped_high
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [SET_W-1:0]   cfg_data = '0;

  typedef struct packed {
    logic [15:0] level;
    logic        clip;
  } corrected_t;

  corrected_t       level_queue[$];
  logic [15:0]      contrast_r, brightness_r, gamma_r;
  logic [14:0]      strength_r;
  int               fail_count = 0;
  longint unsigned  cycle_count = 0;
  logic             sink_stall = 1'b0;
  int               stall_mode = 0;

  pixel_channel_correction u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd2000000) begin
      $display("pixel_channel_correction test failed");
      $finish;
    end
  end

  function automatic longint sat_set(input logic [15:0] v);
    longint s;
    s = longint'($signed(v));
    if (s > 16384) s = 16384;
    if (s < -16384) s = -16384;
    return s;
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned power_q30(input longint unsigned x,
                                                input longint unsigned e);
    int n;
    longint unsigned m, frac, lneg, t, ip, f, r, c;
    if (x == 0) return 0;
    n = 0;
    frac = 0;
    m = x;
    while (m < (64'd1 << 30)) begin
      m = m << 1;
      n++;
    end
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lneg = (longint'(n) << 24) - frac;
    t = (lneg * e + 32768) >> 16;
    ip = t >> 24;
    f = t & 64'hFFFFFF;
    r = 64'd1 << 30;
    c = int_sqrt(64'd1 << 59);
    for (int i = 0; i < 24; i++) begin
      if (f[23-i]) r = (r * c + (64'd1 << 29)) >> 30;
      c = int_sqrt(c << 30);
    end
    if (ip >= 31) return 0;
    return r >> ip;
  endfunction

  function automatic corrected_t correct_level(input logic [15:0] lvl);
    longint mult, cs, bs, gs, gm, k, b, w, d;
    longint unsigned x, g, e2, e4, u, c, fs;
    corrected_t res;
    fs = 65535;
    mult = longint'(strength_r);
    if (mult > 16384) mult = 16384;
    cs = sat_set(contrast_r);
    bs = sat_set(brightness_r);
    gs = sat_set(gamma_r);
    x = ((longint'(lvl) << 30) + fs / 2) / fs;
    gm = rnd_shift(gs * mult, 14);
    if (gs >= 0) begin
      d = 16384 + gm;
      g = ((64'd1 << 30) + d / 2) / d;
    end else begin
      g = (16384 - gm) << 2;
    end
    e2 = (g * g + 32768) >> 16;
    e4 = (e2 * e2 + 32768) >> 16;
    u = power_q30(x, e4);
    k = rnd_shift(cs * mult, 14);
    if (cs <= 0) begin
      c = (k + 16384) << 2;
    end else begin
      d = 16384 - k;
      if (d <= 0) c = 64'd64 << 16;
      else c = ((64'd1 << 30) + d / 2) / d;
    end
    if (c > (64'd64 << 16)) c = 64'd64 << 16;
    w = rnd_shift((longint'(u) - (longint'(1) << 29)) * longint'(c), 16) + (longint'(1) << 29);
    b = rnd_shift(bs * mult, 14);
    w = w + b * 65536;
    if (w < 0) w = 0;
    if (w > (longint'(1) << 30)) begin
      res.clip = 1'b1;
      res.level = 16'hFFFF;
    end else begin
      res.clip = 1'b0;
      res.level = 16'((longint'(w) * 65535 + (longint'(1) << 29)) >>> 30);
    end
    return res;
  endfunction

  // receiver stalls: none, light random or heavy random
  always @(posedge clk) begin
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    corrected_t exp_word;
    if (!rst && m_tvalid && m_tready) begin
      if (level_queue.size() == 0) begin
        $error("unexpected word level_out=%0d clipped_high=%0b", m_tdata, m_tuser);
        fail_count++;
      end else begin
        exp_word = level_queue.pop_front();
        if (m_tdata !== exp_word.level) begin
          $error("level_out expected %0d actual %0d", exp_word.level, m_tdata);
          fail_count++;
        end
        if (m_tuser !== exp_word.clip) begin
          $error("clipped_high expected %0b actual %0b", exp_word.clip, m_tuser);
          fail_count++;
        end
      end
    end
  end

  task automatic send_level(input logic [15:0] lvl);
    s_tvalid <= 1'b1;
    s_tdata  <= lvl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    level_queue.push_back(correct_level(lvl));
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_sender();
    @(posedge clk);
    while (level_queue.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CONTRAST:   contrast_r   = val;
      REG_BRIGHTNESS: brightness_r = val;
      REG_GAMMA:      gamma_r      = val;
      default:        strength_r   = val[14:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(input logic [15:0] cs, input logic [15:0] bs,
                         input logic [15:0] gs, input logic [15:0] st);
    drain();
    write_reg(REG_CONTRAST, cs);
    write_reg(REG_BRIGHTNESS, bs);
    write_reg(REG_GAMMA, gs);
    write_reg(REG_STRENGTH, st);
  endtask

  task automatic send_burst_random(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      send_level(16'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 6);
        idle_sender();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic test_directed_levels();
    logic [15:0] lv[] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h8000,
                          16'h7FFF, 16'h5555, 16'hAAAA, 16'h0100};
    stall_mode = 0;
    foreach (lv[i]) send_level(lv[i]);
    drain();
  endtask

  logic [15:0] lv_ex[] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};

  task automatic test_setting_extremes();
    // max gain, tiny gamma result, clipping at top and bottom
    set_all(16'sd16384, 16'sd16384, 16'sd16384, 15'd16384);
    foreach (lv_ex[i]) send_level(lv_ex[i]);
    set_all(-16'sd16384, -16'sd16384, -16'sd16384, 15'd16384);
    foreach (lv_ex[i]) send_level(lv_ex[i]);
    // out-of-range settings and strength
    set_all(16'h7FFF, 16'h8000, 16'h8000, 15'h7FFF);
    foreach (lv_ex[i]) send_level(lv_ex[i]);
    set_all(16'h8000, 16'h7FFF, 16'h7FFF, 15'd0);
    foreach (lv_ex[i]) send_level(lv_ex[i]);
    drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 12; p++) begin
      if (p == 0) set_all(16'h0, 16'h0, 16'h0, 15'd16384);
      else set_all(16'($urandom_range(0, 32768) - 16384),
                   16'($urandom_range(0, 32768) - 16384),
                   16'($urandom_range(0, 32768) - 16384),
                   15'($urandom_range(0, 16384)));
      if (p % 4 == 3) begin
        write_reg(REG_CONTRAST, 16'($urandom));
        write_reg(REG_STRENGTH, 16'($urandom));
      end
      stall_mode = p % 3;
      send_burst_random(40 + $urandom_range(0, 20));
      // sender holds off until all words have come back
      idle_sender();
      while (level_queue.size() != 0) @(posedge clk);
      send_burst_random(20);
    end
    drain();
  endtask

  initial begin
    contrast_r   = '0;
    brightness_r = '0;
    gamma_r      = '0;
    strength_r   = 15'd16384;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_levels();
    test_setting_extremes();
    test_random_phases();
    if (fail_count == 0) begin
      $display("pixel_channel_correction test passed");
    end else begin
      $display("pixel_channel_correction test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pcc_pkg.sv
design/pixel_channel_correction.sv
tb/sv/tb_top.sv
